// ----- rtl/smfb_pkg.sv -----
package smfb_pkg;

  localparam int MAX_LEN = 64;
  localparam int IDX_W   = $clog2(MAX_LEN);
  localparam int CNT_W   = IDX_W + 1;

  localparam int EX_W    = 31;
  localparam int SUM_W   = 37;
  localparam int DOT_W   = 54;
  localparam int QUO_W   = 17;

  localparam logic [63:0] Q30_HALF     = 64'd536870912;
  localparam logic [30:0] Q30_ONE      = 31'd1073741824;
  localparam logic [31:0] E_INV_Q30    = 32'd395007542;
  localparam logic [32:0] CLAMP_Q16    = 33'd1966080;
  localparam logic [3:0]  SERIES_TERMS = 4'd12;

  typedef enum logic [4:0] {
    S_LOAD,
    S_F_RD,
    S_F_DIFF,
    S_F_WHOLE_MUL,
    S_F_WHOLE_ACC,
    S_F_TERM_MUL,
    S_F_TERM_RND,
    S_F_TERM_REC,
    S_F_TERM_DIV,
    S_F_TERM_ACC,
    S_F_PROD,
    S_F_RES,
    S_D_RD,
    S_D_INIT,
    S_D_STEP,
    S_B1_RD,
    S_B1_MAG,
    S_B1_MUL,
    S_B1_ACC,
    S_B2_RD,
    S_B2_MAG,
    S_B2_LO,
    S_B2_HI,
    S_B2_SUM,
    S_EMIT
  } state_t;

  function automatic logic [31:0] recip(input logic [3:0] k);
    logic [31:0] r;
    unique case (k)
      4'd1:    r = 32'hFFFF_FFFF;
      4'd2:    r = 32'h8000_0000;
      4'd3:    r = 32'h5555_5555;
      4'd4:    r = 32'h4000_0000;
      4'd5:    r = 32'h3333_3333;
      4'd6:    r = 32'h2AAA_AAAA;
      4'd7:    r = 32'h2492_4924;
      4'd8:    r = 32'h2000_0000;
      4'd9:    r = 32'h1C71_C71C;
      4'd10:   r = 32'h1999_9999;
      4'd11:   r = 32'h1745_D174;
      4'd12:   r = 32'h1555_5555;
      default: r = 32'hFFFF_FFFF;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/smfb_ram.sv -----
module smfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/softmax_forward_backward.sv -----
// Softmax forward and backward over one vector of signed Q16.16 words.
// Input channel: one word per element; in_last_in closes the vector and
// in_operation of the first word picks forward (0) or backward (1).
// Elements past 64 are dropped and out_overflow is set on every result.
// Loading takes one word per cycle. After the closing word the block is
// busy with one shared 32x32 multiplier and a bit-serial divider:
//   forward:  per element the exponential (whole-unit steps, then the
//             series terms), then for each result the 17-step division
//             and output.
//   backward: a pass over all elements for the dot product, then each result.
// Results come out in input order, out_last_out on the final one.
// A stalled receiver holds the sequencer at the output register; the
// final result may wait there while the next vector loads.
// cfg_flush_threshold is written through its own channel, always ready.
// Reset (rst_n low, synchronous) empties the vector, clears the threshold
// and drops any pending result.
module softmax_forward_backward (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [15:0] cfg_flush_threshold,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_operation,
  input  logic signed [31:0] in_value_a,
  input  logic signed [31:0] in_value_b,
  input  logic        in_last_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [31:0] out_result_value,
  output logic        out_last_out,
  output logic        out_overflow
);

  smfb_pkg::state_t state_r, state_nxt;

  logic [smfb_pkg::CNT_W-1:0] count_r, count_nxt;
  logic [smfb_pkg::IDX_W-1:0] idx_r, idx_nxt;
  logic signed [31:0] max_r, max_nxt;
  logic mode_r, mode_nxt;
  logic ovf_r, ovf_nxt;
  logic [15:0] thr_r;

  logic [30:0] whole_r, whole_nxt;
  logic [4:0]  cnt_r, cnt_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [30:0] term_r, term_nxt;
  logic signed [32:0] part_r, part_nxt;
  logic [3:0]  k_r, k_nxt;
  logic [30:0] x_r, x_nxt;
  logic [smfb_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [smfb_pkg::SUM_W:0]   rem_r, rem_nxt;
  logic [smfb_pkg::QUO_W-1:0] quo_r, quo_nxt;
  logic [31:0] ma_r, ma_nxt;
  logic [53:0] mt_r, mt_nxt;
  logic neg_r, neg_nxt;
  logic [63:0] lo_r, lo_nxt;
  logic signed [smfb_pkg::DOT_W-1:0] dot_r, dot_nxt;
  logic signed [31:0] res_r, res_nxt;

  logic out_valid_r, out_valid_nxt;
  logic signed [31:0] out_value_r, out_value_nxt;
  logic out_last_r, out_last_nxt;
  logic out_ovf_r, out_ovf_nxt;

  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p_r;

  logic        wr_ab, wr_e;
  logic [31:0] rd_a, rd_b;
  logic [smfb_pkg::EX_W-1:0] rd_e, wr_e_data;

  logic        in_acc;
  logic        mode_eff;
  logic        at_last;
  logic [63:0] rnd30;
  logic signed [32:0] diff, diff_c;
  logic [34:0] qk;
  logic [34:0] rr;
  logic [30:0] q0;
  logic [30:0] res30;
  logic [47:0] num;
  logic [smfb_pkg::SUM_W:0] rem_sh;
  logic [47:0] prnd;
  logic signed [smfb_pkg::DOT_W-1:0] tsum;
  logic [79:0] full;
  logic [64:0] p16;
  logic [31:0] lim;
  logic [31:0] mag;
  logic [31:0] res_mag;
  logic [30:0] part_c;

  smfb_ram #(.WIDTH(32), .DEPTH(smfb_pkg::MAX_LEN)) u_ram_a (
    .clk(clk), .we(wr_ab), .waddr(count_r[smfb_pkg::IDX_W-1:0]), .wdata(in_value_a),
    .raddr(idx_r), .rdata(rd_a)
  );

  smfb_ram #(.WIDTH(32), .DEPTH(smfb_pkg::MAX_LEN)) u_ram_b (
    .clk(clk), .we(wr_ab), .waddr(count_r[smfb_pkg::IDX_W-1:0]), .wdata(in_value_b),
    .raddr(idx_r), .rdata(rd_b)
  );

  smfb_ram #(.WIDTH(smfb_pkg::EX_W), .DEPTH(smfb_pkg::MAX_LEN)) u_ram_e (
    .clk(clk), .we(wr_e), .waddr(idx_r), .wdata(wr_e_data),
    .raddr(idx_r), .rdata(rd_e)
  );

  assign cfg_ready        = 1'b1;
  assign in_ready         = (state_r == smfb_pkg::S_LOAD);
  assign out_valid        = out_valid_r;
  assign out_result_value = out_value_r;
  assign out_last_out     = out_last_r;
  assign out_overflow     = out_ovf_r;

  assign in_acc   = in_valid && in_ready;
  assign mode_eff = (count_r == '0) ? in_operation : mode_r;
  assign at_last  = ({1'b0, idx_r} == count_r - smfb_pkg::CNT_W'(1));

  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= smfb_pkg::S_LOAD;
      count_r     <= '0;
      max_r       <= '0;
      mode_r      <= 1'b0;
      ovf_r       <= 1'b0;
      thr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      max_r       <= max_nxt;
      mode_r      <= mode_nxt;
      ovf_r       <= ovf_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        thr_r <= cfg_flush_threshold;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx_r       <= idx_nxt;
    whole_r     <= whole_nxt;
    cnt_r       <= cnt_nxt;
    frac_r      <= frac_nxt;
    term_r      <= term_nxt;
    part_r      <= part_nxt;
    k_r         <= k_nxt;
    x_r         <= x_nxt;
    sum_r       <= sum_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    ma_r        <= ma_nxt;
    mt_r        <= mt_nxt;
    neg_r       <= neg_nxt;
    lo_r        <= lo_nxt;
    dot_r       <= dot_nxt;
    res_r       <= res_nxt;
    out_value_r <= out_value_nxt;
    out_last_r  <= out_last_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    idx_nxt       = idx_r;
    max_nxt       = max_r;
    mode_nxt      = mode_r;
    ovf_nxt       = ovf_r;
    whole_nxt     = whole_r;
    cnt_nxt       = cnt_r;
    frac_nxt      = frac_r;
    term_nxt      = term_r;
    part_nxt      = part_r;
    k_nxt         = k_r;
    x_nxt         = x_r;
    sum_nxt       = sum_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    ma_nxt        = ma_r;
    mt_nxt        = mt_r;
    neg_nxt       = neg_r;
    lo_nxt        = lo_r;
    dot_nxt       = dot_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_value_nxt = out_value_r;
    out_last_nxt  = out_last_r;
    out_ovf_nxt   = out_ovf_r;
    mul_a         = '0;
    mul_b         = '0;
    wr_ab         = 1'b0;
    wr_e          = 1'b0;

    rnd30     = mul_p_r + smfb_pkg::Q30_HALF;
    diff      = {max_r[31], max_r} - {rd_a[31], rd_a};
    diff_c    = diff;
    if (diff < 0) begin
      diff_c = '0;
    end else if (diff > $signed(smfb_pkg::CLAMP_Q16)) begin
      diff_c = $signed(smfb_pkg::CLAMP_Q16);
    end
    q0        = mul_p_r[62:32];
    qk        = 35'(q0) * 35'(k_r);
    rr        = 35'(x_r) - qk;
    res30     = rnd30[60:30];
    if (res30 == '0) begin
      res30 = 31'd1;
    end else if (res30 > smfb_pkg::Q30_ONE) begin
      res30 = smfb_pkg::Q30_ONE;
    end
    wr_e_data = res30;
    num       = {1'b0, rd_e, 16'b0} + 48'(sum_r >> 1);
    rem_sh    = {rem_r[smfb_pkg::SUM_W-1:0], quo_r[smfb_pkg::QUO_W-1]};
    prnd      = mul_p_r[63:16] + 48'(mul_p_r[15]);
    tsum      = smfb_pkg::DOT_W'($signed(rd_b)) - dot_r;
    full      = {16'b0, lo_r} + {mul_p_r[47:0], 32'b0};
    p16       = 65'(full[79:16]) + 65'(full[15]);
    lim       = neg_r ? 32'h8000_0000 : 32'h7FFF_FFFF;
    mag       = ((mt_r[53:48] != '0 && ma_r != '0) || p16 > 65'(lim)) ? lim : p16[31:0];
    res_mag   = res_r[31] ? 32'(-res_r) : 32'(res_r);
    part_c    = part_r[32] ? '0 :
                (part_r > 33'(smfb_pkg::Q30_ONE)) ? smfb_pkg::Q30_ONE : part_r[30:0];

    unique case (state_r)
      smfb_pkg::S_LOAD: begin
        if (in_acc) begin
          if (count_r == '0) begin
            mode_nxt = in_operation;
          end
          if (count_r < smfb_pkg::CNT_W'(smfb_pkg::MAX_LEN)) begin
            wr_ab     = 1'b1;
            count_nxt = count_r + smfb_pkg::CNT_W'(1);
            if (in_value_a > max_r) begin
              max_nxt = in_value_a;
            end
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_last_in) begin
            idx_nxt   = '0;
            sum_nxt   = '0;
            dot_nxt   = '0;
            state_nxt = mode_eff ? smfb_pkg::S_B1_RD : smfb_pkg::S_F_RD;
          end
        end
      end

      smfb_pkg::S_F_RD: begin
        state_nxt = smfb_pkg::S_F_DIFF;
      end

      smfb_pkg::S_F_DIFF: begin
        whole_nxt = smfb_pkg::Q30_ONE;
        term_nxt  = smfb_pkg::Q30_ONE;
        part_nxt  = 33'(smfb_pkg::Q30_ONE);
        k_nxt     = 4'd1;
        cnt_nxt   = diff_c[20:16];
        frac_nxt  = diff_c[15:0];
        state_nxt = (diff_c[20:16] == '0) ? smfb_pkg::S_F_TERM_MUL : smfb_pkg::S_F_WHOLE_MUL;
      end

      smfb_pkg::S_F_WHOLE_MUL: begin
        mul_a     = 32'(whole_r);
        mul_b     = smfb_pkg::E_INV_Q30;
        state_nxt = smfb_pkg::S_F_WHOLE_ACC;
      end

      smfb_pkg::S_F_WHOLE_ACC: begin
        whole_nxt = rnd30[60:30];
        cnt_nxt   = cnt_r - 5'd1;
        state_nxt = (cnt_r == 5'd1) ? smfb_pkg::S_F_TERM_MUL : smfb_pkg::S_F_WHOLE_MUL;
      end

      smfb_pkg::S_F_TERM_MUL: begin
        mul_a     = 32'(term_r);
        mul_b     = {2'b0, frac_r, 14'b0};
        state_nxt = smfb_pkg::S_F_TERM_RND;
      end

      smfb_pkg::S_F_TERM_RND: begin
        x_nxt     = rnd30[60:30];
        state_nxt = smfb_pkg::S_F_TERM_REC;
      end

      smfb_pkg::S_F_TERM_REC: begin
        mul_a     = 32'(x_r);
        mul_b     = smfb_pkg::recip(k_r);
        state_nxt = smfb_pkg::S_F_TERM_DIV;
      end

      smfb_pkg::S_F_TERM_DIV: begin
        term_nxt  = (rr >= 35'(k_r)) ? q0 + 31'd1 : q0;
        state_nxt = smfb_pkg::S_F_TERM_ACC;
      end

      smfb_pkg::S_F_TERM_ACC: begin
        part_nxt = k_r[0] ? part_r - $signed(33'(term_r)) : part_r + $signed(33'(term_r));
        k_nxt    = k_r + 4'd1;
        state_nxt = (k_r == smfb_pkg::SERIES_TERMS) ? smfb_pkg::S_F_PROD
                                                    : smfb_pkg::S_F_TERM_MUL;
      end

      smfb_pkg::S_F_PROD: begin
        mul_a     = 32'(whole_r);
        mul_b     = 32'(part_c);
        state_nxt = smfb_pkg::S_F_RES;
      end

      smfb_pkg::S_F_RES: begin
        wr_e    = 1'b1;
        sum_nxt = sum_r + smfb_pkg::SUM_W'(res30);
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = smfb_pkg::S_D_RD;
        end else begin
          idx_nxt   = idx_r + smfb_pkg::IDX_W'(1);
          state_nxt = smfb_pkg::S_F_RD;
        end
      end

      smfb_pkg::S_D_RD: begin
        state_nxt = smfb_pkg::S_D_INIT;
      end

      smfb_pkg::S_D_INIT: begin
        rem_nxt   = (smfb_pkg::SUM_W + 1)'(num[47:17]);
        quo_nxt   = num[16:0];
        cnt_nxt   = 5'(smfb_pkg::QUO_W);
        state_nxt = smfb_pkg::S_D_STEP;
      end

      smfb_pkg::S_D_STEP: begin
        if (rem_sh >= {1'b0, sum_r}) begin
          rem_nxt = rem_sh - {1'b0, sum_r};
          quo_nxt = {quo_r[smfb_pkg::QUO_W-2:0], 1'b1};
        end else begin
          rem_nxt = rem_sh;
          quo_nxt = {quo_r[smfb_pkg::QUO_W-2:0], 1'b0};
        end
        cnt_nxt = cnt_r - 5'd1;
        if (cnt_r == 5'd1) begin
          res_nxt   = 32'(quo_nxt);
          state_nxt = smfb_pkg::S_EMIT;
        end
      end

      smfb_pkg::S_B1_RD: begin
        state_nxt = smfb_pkg::S_B1_MAG;
      end

      smfb_pkg::S_B1_MAG: begin
        ma_nxt    = rd_a[31] ? -rd_a : rd_a;
        mt_nxt    = 54'(rd_b[31] ? -rd_b : rd_b);
        neg_nxt   = rd_a[31] ^ rd_b[31];
        state_nxt = smfb_pkg::S_B1_MUL;
      end

      smfb_pkg::S_B1_MUL: begin
        mul_a     = ma_r;
        mul_b     = mt_r[31:0];
        state_nxt = smfb_pkg::S_B1_ACC;
      end

      smfb_pkg::S_B1_ACC: begin
        dot_nxt = neg_r ? dot_r - $signed(smfb_pkg::DOT_W'(prnd))
                        : dot_r + $signed(smfb_pkg::DOT_W'(prnd));
        if (at_last) begin
          idx_nxt   = '0;
          state_nxt = smfb_pkg::S_B2_RD;
        end else begin
          idx_nxt   = idx_r + smfb_pkg::IDX_W'(1);
          state_nxt = smfb_pkg::S_B1_RD;
        end
      end

      smfb_pkg::S_B2_RD: begin
        state_nxt = smfb_pkg::S_B2_MAG;
      end

      smfb_pkg::S_B2_MAG: begin
        ma_nxt    = rd_a[31] ? -rd_a : rd_a;
        mt_nxt    = tsum[smfb_pkg::DOT_W-1] ? 54'(-tsum) : 54'(tsum);
        neg_nxt   = rd_a[31] ^ tsum[smfb_pkg::DOT_W-1];
        state_nxt = smfb_pkg::S_B2_LO;
      end

      smfb_pkg::S_B2_LO: begin
        mul_a     = ma_r;
        mul_b     = mt_r[31:0];
        state_nxt = smfb_pkg::S_B2_HI;
      end

      smfb_pkg::S_B2_HI: begin
        lo_nxt    = mul_p_r;
        mul_a     = ma_r;
        mul_b     = 32'(mt_r[47:32]);
        state_nxt = smfb_pkg::S_B2_SUM;
      end

      smfb_pkg::S_B2_SUM: begin
        res_nxt   = neg_r ? 32'(-mag) : mag;
        state_nxt = smfb_pkg::S_EMIT;
      end

      smfb_pkg::S_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_value_nxt = (res_mag < 32'(thr_r)) ? '0 : res_r;
          out_last_nxt  = at_last;
          out_ovf_nxt   = ovf_r;
          if (at_last) begin
            count_nxt = '0;
            max_nxt   = '0;
            mode_nxt  = 1'b0;
            ovf_nxt   = 1'b0;
            state_nxt = smfb_pkg::S_LOAD;
          end else begin
            idx_nxt   = idx_r + smfb_pkg::IDX_W'(1);
            state_nxt = mode_r ? smfb_pkg::S_B2_RD : smfb_pkg::S_D_RD;
          end
        end
      end

      default: begin
        state_nxt = smfb_pkg::S_LOAD;
      end
    endcase
  end

endmodule

// ----- tb/sv/softmax_forward_backward_tb.sv -----
`timescale 1ns / 1ps

module softmax_forward_backward_tb;

  localparam int STALL_LIMIT = 60000;
  localparam int HOLD_OFF    = 3000;

  typedef struct packed {
    logic [31:0] value;
    logic        last;
    logic        ovf;
  } prob_word_t;

  typedef struct packed {
    logic        op;
    logic [31:0] a;
    logic [31:0] b;
    logic        last;
    logic        pinned;
    logic [31:0] pin_value;
  } vec_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [15:0] cfg_flush_threshold = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic in_operation = 1'b0;
  logic signed [31:0] in_value_a = '0;
  logic signed [31:0] in_value_b = '0;
  logic in_last_in = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] out_result_value;
  logic out_last_out;
  logic out_overflow;

  softmax_forward_backward dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_flush_threshold(cfg_flush_threshold),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_operation(in_operation), .in_value_a(in_value_a), .in_value_b(in_value_b),
    .in_last_in(in_last_in),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_result_value(out_result_value), .out_last_out(out_last_out),
    .out_overflow(out_overflow)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  prob_word_t  pending_probs[$];
  int          errors = 0;
  int          idle_cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  logic        cur_pinned = 1'b0;
  logic [31:0] cur_pin = '0;

  logic [15:0] thr_m = '0;
  logic [31:0] vec_a[smfb_pkg::MAX_LEN];
  logic [31:0] vec_b[smfb_pkg::MAX_LEN];
  logic        vec_pinned[smfb_pkg::MAX_LEN];
  logic [31:0] vec_pin[smfb_pkg::MAX_LEN];
  int          vec_len = 0;
  logic signed [31:0] vec_max = '0;
  logic        vec_op = 1'b0;
  logic        vec_ovf = 1'b0;

  function automatic longint unsigned exp_neg(logic [31:0] u);
    longint unsigned whole, f, term, res;
    longint part;
    whole = 64'd1 << 30;
    term = 64'd1 << 30;
    part = 64'sd1 << 30;
    for (int i = 0; i < int'(u[31:16]); i++)
      whole = (whole * 64'd395007542 + (64'd1 << 29)) >> 30;
    f = longint'(u[15:0]) << 14;
    for (int k = 1; k <= 12; k++) begin
      term = ((term * f + (64'd1 << 29)) >> 30) / longint'(k);
      if (k % 2 == 1) part -= longint'(term);
      else part += longint'(term);
    end
    if (part < 0) part = 0;
    if (part > (64'sd1 << 30)) part = 64'sd1 << 30;
    res = (whole * longint'(part) + (64'd1 << 29)) >> 30;
    if (res < 1) res = 1;
    if (res > (64'd1 << 30)) res = 64'd1 << 30;
    return res;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  function automatic logic [31:0] mul_sat(longint a, longint b);
    longint unsigned ma, mb, p, lim;
    bit neg;
    ma = mag(a);
    mb = mag(b);
    neg = (a < 0) != (b < 0) && a != 0 && b != 0;
    lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
    if (ma != 0 && mb > 64'hFFFF_FFFF_FFFF_FFFF / ma) p = lim;
    else begin
      p = ma * mb;
      p = (p >> 16) + ((p >> 15) & 1);
      if (p > lim) p = lim;
    end
    return neg ? 32'(-longint'(p)) : 32'(p);
  endfunction

  function automatic logic [31:0] flush_small(logic [31:0] v);
    return (mag(longint'($signed(v))) < longint'(thr_m)) ? 32'd0 : v;
  endfunction

  task automatic emit_vector();
    longint unsigned ex[smfb_pkg::MAX_LEN];
    longint unsigned sum, p;
    longint d, dot, t;
    logic [31:0] r;
    prob_word_t w;
    sum = 0;
    dot = 0;
    if (!vec_op) begin
      for (int i = 0; i < vec_len; i++) begin
        d = longint'(vec_max) - longint'($signed(vec_a[i]));
        if (d < 0) d = 0;
        if (d > (64'sd30 << 16)) d = 64'sd30 << 16;
        ex[i] = exp_neg(32'(d));
        sum += ex[i];
      end
    end else begin
      for (int i = 0; i < vec_len; i++) begin
        p = mag($signed(vec_a[i])) * mag($signed(vec_b[i]));
        p = (p >> 16) + ((p >> 15) & 1);
        if (($signed(vec_a[i]) < 0) != ($signed(vec_b[i]) < 0)
            && vec_a[i] != 0 && vec_b[i] != 0) dot -= longint'(p);
        else dot += longint'(p);
      end
    end
    for (int i = 0; i < vec_len; i++) begin
      if (!vec_op) r = 32'((ex[i] * 65536 + sum / 2) / sum);
      else begin
        t = longint'($signed(vec_b[i])) - dot;
        r = mul_sat(longint'($signed(vec_a[i])), t);
      end
      w.value = vec_pinned[i] ? vec_pin[i] : flush_small(r);
      w.last = (i + 1 == vec_len);
      w.ovf = vec_ovf;
      pending_probs.push_back(w);
    end
    vec_len = 0;
    vec_max = '0;
    vec_op = 1'b0;
    vec_ovf = 1'b0;
  endtask

  task automatic absorb_word();
    if (vec_len == 0) vec_op = in_operation;
    if (vec_len < smfb_pkg::MAX_LEN) begin
      vec_a[vec_len] = in_value_a;
      vec_b[vec_len] = in_value_b;
      vec_pinned[vec_len] = cur_pinned;
      vec_pin[vec_len] = cur_pin;
      if (in_value_a > vec_max) vec_max = in_value_a;
      vec_len++;
    end else vec_ovf = 1'b1;
    if (in_last_in) emit_vector();
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) thr_m = cfg_flush_threshold;
      if (in_valid && in_ready) absorb_word();
      if (out_valid && out_ready) begin
        if (pending_probs.size() == 0) begin
          $error("unexpected result word value=%0h", out_result_value);
          errors++;
        end else begin
          prob_word_t w;
          w = pending_probs.pop_front();
          if (out_result_value !== w.value) begin
            $error("result_value expected %0h actual %0h", w.value, out_result_value);
            errors++;
          end
          if (out_last_out !== w.last) begin
            $error("last_out expected %0b actual %0b", w.last, out_last_out);
            errors++;
          end
          if (out_overflow !== w.ovf) begin
            $error("overflow expected %0b actual %0b", w.ovf, out_overflow);
            errors++;
          end
        end
      end
      if ((cfg_valid && cfg_ready) || (in_valid && in_ready) || (out_valid && out_ready)
          || (pending_probs.size() == 0 && !in_valid && !cfg_valid))
        idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n;
    @(posedge rst_n);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (HOLD_OFF) @(negedge clk);
        hold_req = 1'b0;
      end
      n = quiet ? 0 : $urandom_range(0, 9);
      if (n > 0) begin
        out_ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready) && !hold_req);
      @(negedge clk);
    end
  end

  task automatic send_word(vec_row_t row);
    int n;
    n = quiet ? 0 : $urandom_range(0, 9);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= row.op;
    in_value_a <= row.a;
    in_value_b <= row.b;
    in_last_in <= row.last;
    cur_pinned = row.pinned;
    cur_pin = row.pin_value;
    do @(posedge clk); while (!(in_valid && in_ready));
    @(negedge clk);
  endtask

  task automatic write_threshold(logic [15:0] v);
    in_valid <= 1'b0;
    while (pending_probs.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_flush_threshold <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [31:0] draw_value(bit op, bit is_b);
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: begin
        if (op && !is_b) return $urandom_range(0, 32'h1_0000);
        return $urandom_range(0, 32'h000A_0000) - 32'h0005_0000;
      end
    endcase
  endfunction

  task automatic send_vector(int len, bit op);
    vec_row_t row;
    for (int i = 0; i < len; i++) begin
      row.op = (i == 0) ? op : 1'($urandom());
      row.a = draw_value(op, 1'b0);
      row.b = draw_value(op, 1'b1);
      row.last = (i == len - 1);
      row.pinned = 1'b0;
      row.pin_value = '0;
      send_word(row);
    end
  endtask

  vec_row_t directed[] = '{
    '{1'b0, 32'h0000_0000, 32'h1234_5678, 1'b1, 1'b1, 32'h0001_0000},
    '{1'b0, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0001_0000},
    '{1'b0, 32'h8000_0000, 32'h0000_0000, 1'b1, 1'b1, 32'h0001_0000},
    '{1'b0, 32'hFF9C_0000, 32'h0, 1'b0, 1'b1, 32'd21845},
    '{1'b0, 32'hFF38_0000, 32'h0, 1'b0, 1'b1, 32'd21845},
    '{1'b0, 32'h8000_0000, 32'h0, 1'b1, 1'b1, 32'd21845},
    '{1'b0, 32'h0001_0000, 32'h7FFF_FFFF, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h0002_0000, 32'h8000_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'hFFFF_8000, 32'h0000_0001, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'h0000_8000, 32'h0001_0000, 1'b0, 1'b0, 32'h0},
    '{1'b0, 32'h0000_8000, 32'hFFFF_0000, 1'b1, 1'b0, 32'h0},
    '{1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 1'b1, 32'h8000_0000},
    '{1'b1, 32'h8000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h7FFF_FFFF},
    '{1'b1, 32'h0000_0000, 32'h8000_0000, 1'b1, 1'b1, 32'h0000_0000},
    '{1'b1, 32'h0000_4000, 32'h0002_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h0000_4000, 32'hFFFE_0000, 1'b0, 1'b0, 32'h0},
    '{1'b1, 32'h0000_8000, 32'h0000_0000, 1'b1, 1'b0, 32'h0}
  };

  initial begin
    logic [15:0] phase_thr[4];
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    foreach (directed[i]) send_word(directed[i]);
    phase_thr = '{16'hFFFF, 16'd1, 16'($urandom_range(2, 400)), 16'd0};
    for (int ph = 0; ph < 4; ph++) begin
      write_threshold(phase_thr[ph]);
      if (ph == 1) begin
        hold_req = 1'b1;
        quiet = 1'b1;
        send_vector(66, 1'b1);
        send_vector(3, 1'b0);
      end
      repeat (2) begin
        int len;
        len = $urandom_range(1, 6);
        quiet = ($urandom_range(0, 3) == 0);
        send_vector(len, 1'($urandom()));
      end
    end
    in_valid <= 1'b0;
    while (pending_probs.size() != 0) @(negedge clk);
    repeat (200) @(negedge clk);
    if (errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/smfb_pkg.sv
rtl/smfb_ram.sv
rtl/softmax_forward_backward.sv
tb/sv/softmax_forward_backward_tb.sv
